### rtl/core/sparse_histogram_table_assert.svh
// Assertion macros used by the histogram table RTL.
`ifndef SPARSE_HISTOGRAM_TABLE_ASSERT_SVH
`define SPARSE_HISTOGRAM_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHTAB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHTAB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/shtab_pkg.sv
`default_nettype none

package shtab_pkg;

  // Widest count that any configuration uses, and the fixed width of the total.
  localparam int CNT_W  = 64;
  localparam int TOT_W  = 48;
  localparam int TSUM_W = CNT_W + 1;
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // Request codes.
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_INC    = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] bin_id;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [47:0] total_count;
    logic [1:0]  status;
  } rsp_t;

  // Request token as it travels down the chain of cells.
  typedef struct packed {
    logic             active;
    logic [1:0]       req_type;
    logic [31:0]      bin_id;
    logic [31:0]      amount;
    logic             done;
    logic             sat;
    logic [CNT_W-1:0] old_cnt;
    logic [CNT_W-1:0] new_cnt;
  } tok_t;

endpackage

`default_nettype wire

### rtl/core/shtab_cell.sv
`default_nettype none

module shtab_cell import shtab_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire tok_t tok_in,
  output tok_t      tok_out,
  output logic      vld
);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}} >> (CNT_W - COUNT_BITS);

  logic [31:0]           key;
  logic [COUNT_BITS-1:0] cnt;
  logic                  hit;
  logic                  take;
  logic                  upd;
  logic                  clr;
  logic [CNT_W-1:0]      old_val;
  logic [CNT_W-1:0]      amt_val;
  logic [TSUM_W-1:0]     inc_sum;
  logic [CNT_W-1:0]      nv;
  logic                  nv_sat;
  tok_t                  tok_next;

  // The token claims this cell on a key match, or on the first free cell,
  // since allocated cells always form a prefix of the chain.
  always_comb begin
    hit     = vld && (key == tok_in.bin_id);
    take    = tok_in.active && !tok_in.done && (tok_in.req_type != REQ_CLEAR) &&
              (hit || !vld);
    upd     = take && (tok_in.req_type != REQ_LOOKUP);
    clr     = tok_in.active && (tok_in.req_type == REQ_CLEAR);
    old_val = hit ? CNT_W'(cnt) : '0;
    amt_val = CNT_W'(tok_in.amount);
    inc_sum = TSUM_W'(old_val) + TSUM_W'(amt_val);
    nv      = old_val;
    nv_sat  = 1'b0;
    case (tok_in.req_type)
      REQ_SET: begin
        if (amt_val > CNT_MAX) begin
          nv     = CNT_MAX;
          nv_sat = 1'b1;
        end else begin
          nv = amt_val;
        end
      end
      REQ_INC: begin
        if (inc_sum > TSUM_W'(CNT_MAX)) begin
          nv     = CNT_MAX;
          nv_sat = 1'b1;
        end else begin
          nv = inc_sum[CNT_W-1:0];
        end
      end
      default: begin
        nv     = old_val;
        nv_sat = 1'b0;
      end
    endcase
    tok_next = tok_in;
    if (take) begin
      tok_next.done    = 1'b1;
      tok_next.old_cnt = old_val;
      tok_next.new_cnt = nv;
      tok_next.sat     = nv_sat;
    end
  end

  // Control: valid bit and the token register towards the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= 1'b0;
      tok_out.active <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
      if (upd) begin
        vld <= 1'b1;
      end
    end
  end

  // Payload: the bin identifier and its count.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (upd) begin
        key <= tok_in.bin_id;
        cnt <= nv[COUNT_BITS-1:0];
      end else if (clr) begin
        cnt <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/shtab_tail.sv
`default_nettype none

module shtab_tail import shtab_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t tok_in,
  input  wire logic rsp_stall,
  output logic      adv,
  output logic      rsp_valid,
  output rsp_t      rsp
);

  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_next;
  logic [TOT_W-1:0]  base;
  logic [CNT_W-1:0]  delta;
  logic [TSUM_W-1:0] sum;
  logic              tot_sat;
  logic [TOT_W-1:0]  tot_upd;
  rsp_t              rsp_next;

  // The whole chain moves whenever the output register is free or being taken.
  assign adv = !rsp_valid || !rsp_stall;

  // Running total update: a set first removes the old count (clamped at zero),
  // then the stored change is added with saturation.
  always_comb begin
    base  = total;
    delta = tok_in.new_cnt - tok_in.old_cnt;
    if (tok_in.req_type == REQ_SET) begin
      base  = (tok_in.old_cnt > CNT_W'(total)) ? '0 : total - tok_in.old_cnt[TOT_W-1:0];
      delta = tok_in.new_cnt;
    end
    sum     = TSUM_W'(base) + TSUM_W'(delta);
    tot_sat = sum > TSUM_W'(TOT_MAX);
    tot_upd = tot_sat ? TOT_MAX : sum[TOT_W-1:0];

    total_next         = total;
    rsp_next.bin_count = tok_in.new_cnt[31:0];
    rsp_next.status    = ST_OK;
    case (tok_in.req_type)
      REQ_CLEAR: begin
        total_next         = '0;
        rsp_next.bin_count = '0;
      end
      REQ_SET, REQ_INC: begin
        if (!tok_in.done) begin
          rsp_next.bin_count = '0;
          rsp_next.status    = ST_FULL;
        end else begin
          total_next = tot_upd;
          if (tok_in.sat || tot_sat) begin
            rsp_next.status = ST_SAT;
          end
        end
      end
      default: begin
        total_next = total;
      end
    endcase
    rsp_next.total_count = total_next;
  end

  // Control: running total and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      total     <= '0;
    end else if (adv) begin
      rsp_valid <= tok_in.active;
      if (tok_in.active) begin
        total <= total_next;
      end
    end
  end

  // Payload: output register.
  always_ff @(posedge clk) begin
    if (adv && tok_in.active) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sparse_histogram_table.sv
// Sparse histogram table: a fully associative table of bin identifiers with
// counts, plus a 48-bit running total of all counts.
// Requests arrive on req (req_valid/req_stall) and each gives exactly one
// result on rsp (rsp_valid/rsp_stall), in request order. A transfer happens
// on a rising edge with valid high and stall low.
// The table is a chain of TABLE_ENTRIES cells; a request travels one cell per
// cycle unless the chain is frozen, and is served by the cell holding its bin
// or by the first free cell, then passes the output register to rsp_valid.
// A new request is taken in every cycle unless the chain is frozen, since each
// cell sees requests in order; throughput is one result per cycle while rsp_stall
// is low. The running total is updated in the last stage, one request per cycle
// while the chain advances. Reset empties the table and zeroes the total; no
// clearing pass is needed. While rsp_stall holds a waiting result, the whole
// chain freezes and req_stall is raised; nothing is dropped or repeated.
`default_nettype none

`include "sparse_histogram_table_assert.svh"

module sparse_histogram_table import shtab_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  tok_t                     tok [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] vld_vec;
  logic                     adv;

  assign req_stall = !adv;

  // Entry token built from the incoming request.
  always_comb begin
    tok[0]          = '0;
    tok[0].active   = req_valid;
    tok[0].req_type = req.req_type;
    tok[0].bin_id   = req.bin_id;
    tok[0].amount   = req.amount;
  end

  // Chain of table cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    shtab_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .tok_in (tok[i]),
      .tok_out(tok[i+1]),
      .vld    (vld_vec[i])
    );
  end

  // Running total and output register.
  shtab_tail u_tail (
    .clk      (clk),
    .rst      (rst),
    .tok_in   (tok[TABLE_ENTRIES]),
    .rsp_stall(rsp_stall),
    .adv      (adv),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

  // Allocated cells always form a prefix of the chain.
  `SHTAB_ASSERT_IMP(a_valid_prefix, clk, rst, 1'b1,
                    (vld_vec & (vld_vec + TABLE_ENTRIES'(1))) == '0, "valid cells are not a prefix")
  // An accepted request enters the first cell.
  `SHTAB_ASSERT_NXT(a_req_enters, clk, rst, req_valid && !req_stall,
                    tok[1].active, "accepted request lost at chain entry")
  // A token leaving the chain becomes a result.
  `SHTAB_ASSERT_NXT(a_tail_result, clk, rst, tok[TABLE_ENTRIES].active && adv,
                    rsp_valid, "token left the chain without a result")
  // A rejected request reports an empty count.
  `SHTAB_ASSERT_IMP(a_full_zero, clk, rst, rsp_valid && (rsp.status == ST_FULL),
                    rsp.bin_count == '0, "rejected request with nonzero count")

endmodule

`default_nettype wire

### verif/sparse_histogram_table_tb.sv
`default_nettype none

module sparse_histogram_table_tb import shtab_pkg::*; ();

  localparam int          BINS        = 64;
  localparam int          LATENCY     = BINS + 1;
  localparam logic [31:0] COUNT_LIMIT = 32'hFFFF_FFFF;
  localparam int          RANDOM_REQS = 1080;
  localparam int          KEY_POOL    = 72;
  localparam int          HOLD_CYCLES = 400;

  // Histogram scoreboard: keeps its own copy of the bin table and the total,
  // predicts the result of every accepted request and checks results in order.
  class hist_scoreboard;
    logic [31:0] bin_key [BINS];
    logic [31:0] bin_cnt [BINS];
    bit          bin_used [BINS];
    logic [47:0] total;
    rsp_t        pending_results [$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned full_seen;
    int unsigned sat_seen;

    function new();
      foreach (bin_used[i]) bin_used[i] = 1'b0;
      total = '0;
      mismatches = 0;
      results_checked = 0;
      full_seen = 0;
      sat_seen = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Adds to the total with saturation; returns 1 when the total clipped.
    function bit bump_total(logic [31:0] delta);
      logic [48:0] sum;
      sum = {1'b0, total} + {17'd0, delta};
      if (sum > {1'b0, TOT_MAX}) begin
        total = TOT_MAX;
        return 1'b1;
      end
      total = sum[47:0];
      return 1'b0;
    endfunction

    // Applies one accepted request to the table and queues the result it gives.
    function void note_request(req_t r);
      rsp_t        res;
      int          slot;
      logic [31:0] old_c;
      logic [31:0] new_c;
      logic [32:0] grown;
      res = '0;
      res.status = ST_OK;
      slot = -1;
      if (r.req_type == REQ_CLEAR) begin
        // Clearing keeps every bin allocated.
        foreach (bin_used[i]) if (bin_used[i]) bin_cnt[i] = '0;
        total = '0;
      end else begin
        foreach (bin_used[i])
          if (slot < 0 && bin_used[i] && bin_key[i] == r.bin_id) slot = i;
        if (r.req_type == REQ_LOOKUP) begin
          if (slot >= 0) res.bin_count = bin_cnt[slot];
        end else begin
          // A new bin takes the lowest free entry, even for a zero amount.
          if (slot < 0) begin
            foreach (bin_used[i]) if (slot < 0 && !bin_used[i]) slot = i;
            if (slot >= 0) begin
              bin_used[slot] = 1'b1;
              bin_key[slot]  = r.bin_id;
              bin_cnt[slot]  = '0;
            end
          end
          if (slot < 0) begin
            res.status = ST_FULL;
          end else begin
            old_c = bin_cnt[slot];
            if (r.req_type == REQ_SET) begin
              // The amount is as wide as the count, so a set cannot clip it.
              new_c = r.amount;
              total = (total >= {16'd0, old_c}) ? total - {16'd0, old_c} : '0;
              if (bump_total(new_c)) res.status = ST_SAT;
            end else begin
              grown = {1'b0, old_c} + {1'b0, r.amount};
              if (grown > {1'b0, COUNT_LIMIT}) begin
                new_c = COUNT_LIMIT;
                res.status = ST_SAT;
              end else begin
                new_c = grown[31:0];
              end
              if (bump_total(new_c - old_c)) res.status = ST_SAT;
            end
            bin_cnt[slot] = new_c;
            res.bin_count = new_c;
          end
        end
      end
      res.total_count = total;
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Compares one result transfer with the oldest expectation.
    task check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_SAT) sat_seen++;
        if (got.bin_count !== want.bin_count)
          report_mismatch($sformatf("bin_count %0h, expected %0h",
                                    got.bin_count, want.bin_count));
        if (got.total_count !== want.total_count)
          report_mismatch($sformatf("total_count %0h, expected %0h",
                                    got.total_count, want.total_count));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    got.status, want.status));
      end
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  bit          quiet        = 1'b0;
  bit          hold_pending = 1'b0;
  int unsigned reqs_sent    = 0;
  logic [31:0] key_pool [KEY_POOL];

  hist_scoreboard sb = new();

  sparse_histogram_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Watch both channels; every signal is sampled as it stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if (req_valid && !req_stall) begin
        sb.note_request(req);
        reqs_sent++;
      end
    end
  end

  // Result side: random stalls, none in the quiet stretch, and one long
  // hold-off so that the chain fills and the request side backs up.
  initial begin
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_stall <= !quiet && ($urandom_range(99) < 33);
        @(posedge clk);
      end
    end
  end

  function automatic req_t make_req(logic [1:0] kind, logic [31:0] key, logic [31:0] amt);
    req_t r;
    r.req_type = kind;
    r.bin_id   = key;
    r.amount   = amt;
    return r;
  endfunction

  // Offers one request, with a random gap in front, and waits for its transfer.
  task automatic send_req(input req_t r);
    if (!quiet && $urandom_range(99) < 33) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
  endtask

  // Drops valid and waits at least one edge, so that the last transfer has
  // been noted before the outstanding count is looked at.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Random request: mostly pool keys so that bins are hit again and the
  // table fills, with a few fresh keys and a rare clear.
  function automatic req_t random_req();
    int          pick;
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] amt;
    pick = $urandom_range(99);
    if (pick < 25)      kind = REQ_LOOKUP;
    else if (pick < 50) kind = REQ_SET;
    else if (pick < 97) kind = REQ_INC;
    else                kind = REQ_CLEAR;
    if ($urandom_range(9) == 0) key = $urandom();
    else key = key_pool[$urandom_range(KEY_POOL - 1)];
    pick = $urandom_range(9);
    if (pick < 4)       amt = $urandom_range(15);
    else if (pick < 8)  amt = $urandom();
    else if (pick == 8) amt = COUNT_LIMIT;
    else                amt = COUNT_LIMIT - $urandom_range(255);
    return make_req(kind, key, amt);
  endfunction

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h5555_AAAA;
    key_pool[3] = 32'hAAAA_5555;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: empty table, zero and full-scale amounts, count
    // saturation, allocation by increase, and clear keeping bins allocated.
    send_req(make_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000));
    send_req(make_req(REQ_CLEAR,  32'h0000_0000, 32'h0000_0000));
    send_req(make_req(REQ_SET,    32'h0000_0000, 32'h0000_0000));
    send_req(make_req(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
    send_req(make_req(REQ_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(make_req(REQ_INC,    32'hFFFF_FFFF, 32'h0000_0001));
    send_req(make_req(REQ_INC,    32'h0000_0000, 32'hFFFF_FFFF));
    send_req(make_req(REQ_INC,    32'h0000_0000, 32'h0000_0000));
    send_req(make_req(REQ_SET,    32'hFFFF_FFFF, 32'h0000_0005));
    send_req(make_req(REQ_INC,    32'h5555_AAAA, 32'hAAAA_5555));
    send_req(make_req(REQ_LOOKUP, 32'h5555_AAAA, 32'h0000_0000));
    send_req(make_req(REQ_LOOKUP, 32'hAAAA_5555, 32'h0000_0000));
    send_req(make_req(REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
    send_req(make_req(REQ_SET,    32'hFFFF_FFFF, 32'h0000_0000));
    send_req(make_req(REQ_INC,    32'h5555_AAAA, 32'hFFFF_FFFF));
    send_req(make_req(REQ_INC,    32'h5555_AAAA, 32'h0000_0001));
    send_req(make_req(REQ_LOOKUP, 32'h5555_AAAA, 32'h0000_0000));

    // Random requests, with a long result hold-off, a stretch with no idling
    // and one pause until every result has come back.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 200) hold_pending = 1'b1;
      if (n == 450) quiet = 1'b1;
      if (n == 650) quiet = 1'b0;
      if (n == 800) wait_for_drain();
      send_req(random_req());
    end

    wait_for_drain();
    repeat (2 * LATENCY + 10) @(posedge clk);

    $display("Sent %0d requests and checked %0d results in order.",
             reqs_sent, sb.results_checked);
    $display("Seen %0d table-full rejections and %0d saturated counts.",
             sb.full_seen, sb.sat_seen);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("Run timed out with %0d results outstanding.", sb.outstanding());
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

### sparse_histogram_table.f
+incdir+rtl/core
rtl/core/shtab_pkg.sv
rtl/core/shtab_cell.sv
rtl/core/shtab_tail.sv
rtl/core/sparse_histogram_table.sv
verif/sparse_histogram_table_tb.sv
